>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a implies b in the same cycle, skipped while rst is high.
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// Check that a implies b in the next cycle, also across reset.
`define ASSERT_NEXT(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

>>> hw/rtl/xtea_pkg.sv
// Types, constants and round helpers for the XTEA block encryptor.
// No dependencies; imported by the cell, the top level and the checker.
package xtea_pkg;

  localparam int ROUNDS = 32;
  localparam int STAGES = 2 * ROUNDS;
  localparam int LATENCY = STAGES;
  localparam logic [31:0] DELTA = 32'h9E3779B9;
  localparam int KEY_WORDS = 4;
  localparam int ADDR_W = 4;

  typedef logic [KEY_WORDS-1:0][31:0] key_t;

  typedef struct packed {
    logic [31:0] block_left;
    logic [31:0] block_right;
  } plain_t;

  typedef struct packed {
    logic [31:0] cipher_left;
    logic [31:0] cipher_right;
  } cipher_t;

  // One item as it moves down the cell chain
  typedef struct packed {
    logic        valid;
    logic [31:0] left;
    logic [31:0] right;
  } stage_t;

  // Running sum seen by half-round j: even j before the step, odd j after it
  function automatic logic [31:0] cell_sum(input int j);
    logic [31:0] r;
    r = 32'((j + 1) / 2);
    return r * DELTA;
  endfunction

  function automatic logic [31:0] mix(input logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

>>> hw/rtl/xtea_block_encrypt.sv
// XTEA encryptor, 64-bit block, 128-bit key, as a chain of half-round cells.
// One registered cell per half-round lies on the path from start to done.
// Throughput: one block per cycle; busy stays low, and done cannot be stalled.
// Reset: synchronous, clears the key registers and all in-flight items.
// Depends on xtea_pkg and xtea_cell.
module xtea_block_encrypt import xtea_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  plain_t            plain,
  output logic              done,
  output cipher_t           cipher,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  key_t   key;
  stage_t chain [STAGES+1];

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Hold key words; write on the APB access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (psel && penable && pwrite) begin
      key[paddr[ADDR_W-1:2]] <= pwdata;
    end
  end

  assign prdata = key[paddr[ADDR_W-1:2]];

  // Feed a new item into the first cell
  always_comb begin
    chain[0].valid = start && !busy;
    chain[0].left  = plain.block_left;
    chain[0].right = plain.block_right;
  end

  // Build the row of half-round cells
  for (genvar j = 0; j < STAGES; j++) begin : g_cell
    localparam logic [31:0] SUM = cell_sum(j);
    localparam logic HALF = (j % 2) == 1;
    xtea_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .sum  (SUM),
      .half (HALF),
      .key  (key),
      .prev (chain[j]),
      .q    (chain[j+1])
    );
  end

  // Drive the result from the last cell
  assign done                = chain[STAGES].valid;
  assign cipher.cipher_left  = chain[STAGES].left;
  assign cipher.cipher_right = chain[STAGES].right;

endmodule

>>> hw/rtl/xtea_cell.sv
// One XTEA half-round: updates the left or the right half and registers it.
// Depends on xtea_pkg.
module xtea_cell import xtea_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] sum,
  input  logic        half,
  input  key_t        key,
  input  stage_t      prev,
  output stage_t      q
);

  logic [1:0]  kidx;
  logic [31:0] round_key;
  logic [31:0] src;
  logic [31:0] dst;
  logic [31:0] dst_next;

  // Pick key word and the half that feeds the mix
  always_comb begin
    kidx      = half ? sum[12:11] : sum[1:0];
    round_key = sum + key[kidx];
    src       = half ? prev.left : prev.right;
    dst       = half ? prev.right : prev.left;
    dst_next  = dst + (mix(src) ^ round_key);
  end

  // Advance the item one cell down the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= prev.valid;
    end
    q.left  <= half ? prev.left : dst_next;
    q.right <= half ? dst_next : prev.right;
  end

endmodule

>>> hw/rtl/xtea_checker.sv
// Port-level checks on the XTEA encryptor, bound to the top level.
// Depends on xtea_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xtea_checker import xtea_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic pready
);

  // No result in the cycle after reset
  `ASSERT_NEXT(a_no_done_after_rst, clk, rst, !done)
  // Every result traces back to an accepted item a fixed latency earlier
  `ASSERT_IMPLIES(a_done_has_item, clk, rst, done, $past(start && !busy, LATENCY))
  // Every accepted item comes out after the fixed latency
  `ASSERT_IMPLIES(a_item_gives_done, clk, rst, start && !busy, ##LATENCY done)
  // The config port never inserts wait states
  `ASSERT_IMPLIES(a_pready_high, clk, rst, 1'b1, pready)

endmodule

bind xtea_block_encrypt xtea_checker u_xtea_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .pready (pready)
);

>>> sim/tb_top.sv
// Self-checking bench for xtea_block_encrypt: queued plaintext items, a clocked driver and
// monitor, and an in-bench XTEA encipher that predicts each ciphertext item.
// Depends on xtea_pkg and the xtea_block_encrypt RTL.
module tb_top import xtea_pkg::*; ;

  localparam int HALF_PERIOD = 6;
  localparam int STALL_LIMIT = 5000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  plain_t            plain = '0;
  logic              done;
  cipher_t           cipher;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Key as the bench believes the block holds it
  key_t    key_shadow = '0;
  plain_t  plain_backlog[$];
  cipher_t cipher_due[$];
  int      errors = 0;
  int      stall_cycles = 0;
  bit      steady = 1'b0;

  xtea_block_encrypt dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .plain(plain),
    .done(done), .cipher(cipher), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [31:0] feistel_mix(input logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  // Run all rounds on one block under the given key
  function automatic cipher_t xtea_encipher(input plain_t p, input key_t k);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
    cipher_t     c;
    v0 = p.block_left;
    v1 = p.block_right;
    sum = '0;
    for (int r = 0; r < ROUNDS; r++) begin
      v0 = v0 + (feistel_mix(v1) ^ (sum + k[sum[1:0]]));
      sum = sum + DELTA;
      v1 = v1 + (feistel_mix(v0) ^ (sum + k[sum[12:11]]));
    end
    c.cipher_left = v0;
    c.cipher_right = v1;
    return c;
  endfunction

  // Mostly uniform words, with extremes and single bits mixed in
  function automatic logic [31:0] rand_word();
    int pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      4: return 32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  // Driver: hold an item until accepted, then advance or idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        cipher_due.push_back(xtea_encipher(plain, key_shadow));
      end
      if (start && busy) begin
        // hold the current item
      end else if (plain_backlog.size() > 0 && (steady || $urandom_range(0, 99) >= 33)) begin
        start <= 1'b1;
        plain <= plain_backlog.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result item with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (cipher_due.size() == 0) begin
        $display("%0t: unexpected result item left=%h right=%h", $time,
                 cipher.cipher_left, cipher.cipher_right);
        errors++;
      end else begin
        cipher_t want;
        want = cipher_due.pop_front();
        if (cipher.cipher_left !== want.cipher_left) begin
          $display("%0t: cipher_left expected %h actual %h", $time,
                   want.cipher_left, cipher.cipher_left);
          errors++;
        end
        if (cipher.cipher_right !== want.cipher_right) begin
          $display("%0t: cipher_right expected %h actual %h", $time,
                   want.cipher_right, cipher.cipher_right);
          errors++;
        end
      end
    end
  end

  // Watchdog: drop the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // One APB write: setup cycle, then access until pready
  task automatic write_key(input int idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    key_shadow[idx[1:0]] = value;
  endtask

  task automatic set_key(input logic [31:0] k0, input logic [31:0] k1,
                         input logic [31:0] k2, input logic [31:0] k3);
    write_key(0, k0);
    write_key(1, k1);
    write_key(2, k2);
    write_key(3, k3);
  endtask

  task automatic queue_block(input logic [31:0] l, input logic [31:0] r);
    plain_t p;
    p.block_left = l;
    p.block_right = r;
    plain_backlog.push_back(p);
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      queue_block(rand_word(), rand_word());
    end
  endtask

  // Wait until every queued item is accepted and every result is back
  task automatic drain();
    do @(negedge clk); while (plain_backlog.size() != 0 || start || cipher_due.size() != 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Key never written: encrypt under the all-zero reset key
    queue_block(32'h0000_0000, 32'h0000_0000);
    queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_block(32'hFFFF_FFFF, 32'h0000_0000);
    queue_block(32'h0000_0000, 32'hFFFF_FFFF);
    queue_block(32'hAAAA_AAAA, 32'h5555_5555);
    queue_block(32'h8000_0000, 32'h0000_0001);
    queue_block(32'h0000_0001, 32'h8000_0000);
    queue_block(32'h4142_4344, 32'h4546_4748);
    drain();

    // Extreme key, then corner blocks and random items
    set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_block(32'h0000_0000, 32'h0000_0000);
    queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_block(32'h5555_5555, 32'hAAAA_AAAA);
    queue_block(32'h7FFF_FFFF, 32'hFFFF_FFFE);
    queue_random(300);
    drain();

    // Random key; back-to-back stretch, full drain, then gappy traffic
    set_key($urandom(), $urandom(), $urandom(), $urandom());
    steady = 1'b1;
    queue_random(400);
    drain();
    steady = 1'b0;
    queue_random(300);
    drain();

    // Distinct extremes per key word, so a wrong word select shows up
    set_key(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    queue_random(300);
    drain();

    // Key cleared by writes
    set_key(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_random(200);
    drain();

    set_key(rand_word(), rand_word(), rand_word(), rand_word());
    queue_random(200);
    drain();

    // Let any stray result show up before closing
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> xtea_block_encrypt.f
+incdir+hw/rtl
hw/rtl/xtea_pkg.sv
hw/rtl/xtea_cell.sv
hw/rtl/xtea_block_encrypt.sv
hw/rtl/xtea_checker.sv
sim/tb_top.sv
